>>> src/s2o_pkg.sv
package s2o_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SeptetW = 7;
  localparam int unsigned PhaseW  = 3;

  // tuser bit positions on the output side
  localparam int unsigned UserHasByte = 0;
  localparam int unsigned UserResync  = 1;
  localparam int unsigned UserW       = 2;

  typedef struct packed {
    logic             has_byte;
    logic [ByteW-1:0] data_byte;
    logic             resync;
  } s2o_result_t;

  // Octet for phase k (1..7): held bits k-1 upward, topped by the low k bits of the new byte.
  function automatic logic [ByteW-1:0] s2o_octet(input logic [SeptetW-1:0] held,
                                                 input logic [ByteW-1:0]   cur,
                                                 input logic [PhaseW-1:0]  k);
    logic [ByteW-1:0] low_part;
    logic [ByteW-1:0] mask;
    logic [ByteW-1:0] high_part;
    logic [3:0]       up_shift;
    low_part  = {1'b0, held} >> (k - PhaseW'(1));
    mask      = (ByteW'(1) << k) - ByteW'(1);
    up_shift  = 4'(ByteW) - {1'b0, k};
    high_part = (cur & mask) << up_shift;
    return low_part | high_part;
  endfunction

endpackage

>>> src/s2o_core.sv
module s2o_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [s2o_pkg::ByteW-1:0] byte_i,
  output s2o_pkg::s2o_result_t      result_o
);
  import s2o_pkg::*;

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [SeptetW-1:0] held_q, held_d;
  logic               mark;

  assign mark = byte_i[ByteW-1];

  always_comb begin
    result_o = '0;
    phase_d  = phase_q;
    held_d   = held_q;
    if (mark) begin
      result_o.resync = 1'b1;
    end else begin
      if (phase_q != '0) begin
        result_o.has_byte  = 1'b1;
        result_o.data_byte = s2o_octet(held_q, byte_i, phase_q);
      end
    end
    if (accept_i) begin
      if (mark) begin
        phase_d = '0;
      end else begin
        phase_d = phase_q + PhaseW'(1);
        held_d  = byte_i[SeptetW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> src/s2o_out_reg.sv
module s2o_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  s2o_pkg::s2o_result_t result_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output s2o_pkg::s2o_result_t result_o
);
  import s2o_pkg::*;

  logic        valid_q, valid_d;
  s2o_result_t data_q;

  assign valid_d = load_i | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

>>> src/septet_to_octet_unpacker.sv
// Septet-to-octet unpacker.
// Slave channel: one stream byte per item on s_axis_tdata_i. Bytes with bit 7
// clear are septets; eight of them unpack into seven octets, low bits first.
// A byte with bit 7 set is a resync marker and restarts the group.
// Master channel: one item per input item. tdata carries the octet, tuser[0]
// says an octet is present, tuser[1] flags a resync. Without an octet tdata is 0.
// Latency: the result of an item is offered on the cycle after it is taken.
// Throughput: one item per cycle unless the receiver stalls; the only work is
// a shift and mask between the group state registers and the output register.
// Reset clears the phase, the held septet and the output valid flag.
// If the receiver stalls, the result holds in the output register and the
// slave side stops accepting; s_axis_tready_o is high whenever the output
// register is empty or is being drained in the same cycle.
module septet_to_octet_unpacker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [s2o_pkg::ByteW-1:0]   s_axis_tdata_i,   // [7:0] in_byte
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [s2o_pkg::ByteW-1:0]   m_axis_tdata_o,   // [7:0] data_byte
  output logic [s2o_pkg::UserW-1:0]   m_axis_tuser_o    // [0] has_byte, [1] resync
);
  import s2o_pkg::*;

  logic        in_accept;
  logic        out_take;
  s2o_result_t step_res;
  s2o_result_t out_res;

  assign out_take        = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = ~m_axis_tvalid_o | m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  s2o_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata_i),
    .result_o (step_res)
  );

  s2o_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_accept),
    .result_i (step_res),
    .take_i   (out_take),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_res)
  );

  assign m_axis_tdata_o              = out_res.data_byte;
  assign m_axis_tuser_o[UserHasByte] = out_res.has_byte;
  assign m_axis_tuser_o[UserResync]  = out_res.resync;

endmodule

>>> src/s2o_checker.sv
module s2o_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [s2o_pkg::ByteW-1:0] s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [s2o_pkg::ByteW-1:0] m_axis_tdata_o,
  input logic [s2o_pkg::UserW-1:0] m_axis_tuser_o
);
  import s2o_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // an item never carries an octet and a resync together
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[UserHasByte] && m_axis_tuser_o[UserResync]))
    else $error("octet and resync on the same item");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[UserHasByte]) |-> (m_axis_tdata_o == '0))
    else $error("data nonzero without an octet");

  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid_o)
    else $error("accepted item gave no result on the next cycle");

  a_marker_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata_i[ByteW-1]) |=> m_axis_tuser_o[UserResync])
    else $error("marker byte did not flag resync");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled item changed");

endmodule

bind septet_to_octet_unpacker s2o_checker u_s2o_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
